// ===== src/tfe_pkg.sv =====
`timescale 1ns / 1ps
// tfe_pkg: shared widths, payload structs, datapath op codes and control structs
// for the triangle fragment evaluator; no dependencies
package tfe_pkg;

	// design constants
	localparam int COORD_BITS      = 12;
	localparam int DEPTH_FRAC_BITS = 14;

	// screen coordinate, signed with 8 fraction bits
	localparam int CW    = COORD_BITS + 9;
	localparam int CW1   = CW + 1;
	// pixel centre is 12 integer bits plus 8 fraction bits, signed
	localparam int X_W   = (CW > 21) ? CW : 21;
	localparam int PD_W  = X_W + 1;
	// vertex depth, signed with two integer bits
	localparam int DW    = DEPTH_FRAC_BITS + 2;
	// edge functions and area
	localparam int E_W   = CW1 + PD_W + 2;
	// second multiplier operand
	localparam int MB_W  = (PD_W > DW) ? PD_W : DW;
	localparam int P_W   = E_W + MB_W;
	// divider numerator, divisor and signed quotient
	localparam int NUM_W = E_W + MB_W + 2;
	localparam int DEN_W = E_W;
	localparam int Q_W   = NUM_W + 1;
	localparam int CNT_W = $clog2(NUM_W);

	// fragment depth scaling to Q1.14
	localparam int FD_SHR = (DEPTH_FRAC_BITS >= 14) ? DEPTH_FRAC_BITS - 14 : 0;
	localparam int FD_SHL = (DEPTH_FRAC_BITS >= 14) ? 0 : 14 - DEPTH_FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADE_MODE    = 2'd2;
	localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
	localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

	// item functions and the slot that is ignored
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	// blend channels
	localparam logic [1:0] CH_DEPTH = 2'd0;
	localparam logic [1:0] CH_RED   = 2'd1;
	localparam logic [1:0] CH_GREEN = 2'd2;
	localparam logic [1:0] CH_BLUE  = 2'd3;

	typedef struct packed {
		logic               func;
		logic [1:0]         vertex_slot;
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic signed [31:0] clip_w;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic [11:0]        pixel_x;
		logic [11:0]        pixel_y;
	} item_t;

	typedef struct packed {
		logic               covered;
		logic               triangle_culled;
		logic signed [15:0] frag_depth;
		logic [7:0]         out_red;
		logic [7:0]         out_green;
		logic [7:0]         out_blue;
		logic [7:0]         out_alpha;
	} result_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LD_MUL_X,
		OP_LD_MUL_Y,
		OP_LD_DIV_X,
		OP_LD_DIV_Y,
		OP_LD_DIV_Z,
		OP_LD_SAVE_X,
		OP_LD_SAVE_Y,
		OP_LD_SAVE_Z,
		OP_LD_WRITE,
		OP_PX_M0,
		OP_PX_M1,
		OP_PX_M2,
		OP_PX_M3,
		OP_PX_M4,
		OP_PX_M5,
		OP_PX_M6,
		OP_PX_E2,
		OP_BL_M0,
		OP_BL_M1,
		OP_BL_M2,
		OP_BL_M3,
		OP_BL_DIV,
		OP_BL_SAVE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       capture;
		logic [1:0] chan;
		logic       covered;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic is_pixel;
		logic slot_ok;
		logic w_pos;
		logic reject;
		logic depth_ok;
		logic shade;
	} dp_status_t;

endpackage

// ===== src/tfe_div.sv =====
`timescale 1ns / 1ps
// tfe_div: shared restoring divider, signed numerator by positive divisor,
// quotient rounded toward minus infinity; uses tfe_pkg
module tfe_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [tfe_pkg::NUM_W-1:0] num,
	input  logic [tfe_pkg::DEN_W-1:0]        den,
	output logic                             busy,
	output logic signed [tfe_pkg::Q_W-1:0]   quo
);
	import tfe_pkg::*;

	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W:0]         trial;
	logic                   fits;
	logic signed [Q_W-1:0]  qpos;

	// one quotient bit per cycle
	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
		end
	end

	// floor correction for negative numerators
	assign qpos = signed'(Q_W'(quo_q));
	assign quo  = neg_q ? (-qpos - Q_W'(rem_q != '0)) : qpos;
	assign busy = busy_q;

endmodule

// ===== src/tfe_datapath.sv =====
`timescale 1ns / 1ps
// tfe_datapath: vertex store, configuration registers, shared multiplier,
// edge and blend accumulators and result register; uses tfe_pkg and tfe_div
module tfe_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tfe_pkg::dp_cmd_t                     cmd,
	input  tfe_pkg::item_t                       item,
	input  logic                                 cfg_we,
	input  logic [tfe_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [tfe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output tfe_pkg::dp_status_t                  stat,
	output tfe_pkg::result_t                     result
);
	import tfe_pkg::*;

	localparam logic signed [Q_W-1:0] Q_CMAX = Q_W'(2 ** (CW - 1) - 1);
	localparam logic signed [Q_W-1:0] Q_CMIN = -Q_W'(2 ** (CW - 1));
	localparam logic signed [Q_W-1:0] Q_DMAX = Q_W'(2 ** (DW - 1) - 1);
	localparam logic signed [Q_W-1:0] Q_DMIN = -Q_W'(2 ** (DW - 1));
	localparam logic signed [DW-1:0]  D_LIM  = DW'(2 ** DEPTH_FRAC_BITS);

	// configuration
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic        shade_q;

	// vertex store
	logic signed [CW-1:0] vx_q [3];
	logic signed [CW-1:0] vy_q [3];
	logic signed [DW-1:0] vz_q [3];
	logic [31:0]          vcol_q [3];
	logic [2:0]           vfront_q;

	// working registers
	item_t                  in_q;
	logic signed [NUM_W-1:0] prod_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [CW-1:0]   sx_q;
	logic signed [CW-1:0]   sy_q;
	logic signed [DW-1:0]   sz_q;
	logic signed [E_W-1:0]  area_q;
	logic signed [E_W-1:0]  e0_q;
	logic signed [E_W-1:0]  e1_q;
	logic signed [E_W-1:0]  e2_q;
	logic signed [DW-1:0]   d_q;
	logic [7:0]             col_q [3];
	result_t                res_q;

	logic signed [32:0]      xw;
	logic signed [32:0]      wy;
	logic signed [PD_W-1:0]  px;
	logic signed [PD_W-1:0]  py;
	logic signed [CW1-1:0]   d10x, d10y, d20x, d20y, d12y, d21x, d02x;
	logic signed [PD_W-1:0]  pxd0, pyd0, pxd2, pyd2;
	logic signed [E_W-1:0]   ma;
	logic signed [MB_W-1:0]  mb;
	logic signed [P_W-1:0]   prod_w;
	logic                    div_start;
	logic signed [NUM_W-1:0] div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_busy;
	logic signed [Q_W-1:0]   quo;
	logic                    culled;
	logic                    on_screen;
	logic                    edges_ok;
	logic signed [31:0]      dx;
	logic signed [15:0]      fd_w;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [Q_W-1:0] q);
		if (q > Q_CMAX) begin
			return CW'(Q_CMAX);
		end else if (q < Q_CMIN) begin
			return CW'(Q_CMIN);
		end
		return CW'(q);
	endfunction

	function automatic logic signed [DW-1:0] sat_depth(input logic signed [Q_W-1:0] q);
		if (q > Q_DMAX) begin
			return DW'(Q_DMAX);
		end else if (q < Q_DMIN) begin
			return DW'(Q_DMIN);
		end
		return DW'(q);
	endfunction

	function automatic logic [7:0] chan_byte(input logic [31:0] c, input logic [1:0] ch);
		case (ch)
			CH_RED:   return c[7:0];
			CH_GREEN: return c[15:8];
			CH_BLUE:  return c[23:16];
			default:  return 8'h00;
		endcase
	endfunction

	function automatic logic signed [MB_W-1:0] blend_val(input logic signed [DW-1:0] z,
			input logic [31:0] c, input logic [1:0] ch);
		if (ch == CH_DEPTH) begin
			return MB_W'(z);
		end
		return signed'(MB_W'(chan_byte(c, ch)));
	endfunction

	// clip sums for the viewport map
	assign xw = 33'(in_q.clip_x) + 33'(in_q.clip_w);
	assign wy = 33'(in_q.clip_w) - 33'(in_q.clip_y);

	// pixel centre and vertex differences
	assign px   = signed'(PD_W'({in_q.pixel_x, 8'h80}));
	assign py   = signed'(PD_W'({in_q.pixel_y, 8'h80}));
	assign d10x = CW1'(vx_q[1]) - CW1'(vx_q[0]);
	assign d10y = CW1'(vy_q[1]) - CW1'(vy_q[0]);
	assign d20x = CW1'(vx_q[2]) - CW1'(vx_q[0]);
	assign d20y = CW1'(vy_q[2]) - CW1'(vy_q[0]);
	assign d12y = CW1'(vy_q[1]) - CW1'(vy_q[2]);
	assign d21x = CW1'(vx_q[2]) - CW1'(vx_q[1]);
	assign d02x = CW1'(vx_q[0]) - CW1'(vx_q[2]);
	assign pxd0 = px - PD_W'(vx_q[0]);
	assign pyd0 = py - PD_W'(vy_q[0]);
	assign pxd2 = px - PD_W'(vx_q[2]);
	assign pyd2 = py - PD_W'(vy_q[2]);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_LD_MUL_X: begin
				ma = E_W'(xw);
				mb = signed'(MB_W'(width_q));
			end
			OP_LD_MUL_Y: begin
				ma = E_W'(wy);
				mb = signed'(MB_W'(height_q));
			end
			OP_PX_M0: begin
				ma = E_W'(d10x);
				mb = MB_W'(d20y);
			end
			OP_PX_M1: begin
				ma = E_W'(d10y);
				mb = MB_W'(d20x);
			end
			OP_PX_M2: begin
				ma = E_W'(d12y);
				mb = MB_W'(pxd2);
			end
			OP_PX_M3: begin
				ma = E_W'(d21x);
				mb = MB_W'(pyd2);
			end
			OP_PX_M4: begin
				ma = E_W'(d20y);
				mb = MB_W'(pxd0);
			end
			OP_PX_M5: begin
				ma = E_W'(d02x);
				mb = MB_W'(pyd0);
			end
			OP_BL_M0: begin
				ma = -e0_q;
				mb = blend_val(vz_q[0], vcol_q[0], cmd.chan);
			end
			OP_BL_M1: begin
				ma = -e1_q;
				mb = blend_val(vz_q[1], vcol_q[1], cmd.chan);
			end
			OP_BL_M2: begin
				ma = -e2_q;
				mb = blend_val(vz_q[2], vcol_q[2], cmd.chan);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_w = ma * mb;

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = num_q;
		div_den   = DEN_W'($unsigned(-area_q));
		case (cmd.op)
			OP_LD_DIV_X, OP_LD_DIV_Y: begin
				div_start = 1'b1;
				div_num   = prod_q <<< 7;
				div_den   = DEN_W'($unsigned(in_q.clip_w));
			end
			OP_LD_DIV_Z: begin
				div_start = 1'b1;
				div_num   = NUM_W'(in_q.clip_z) <<< DEPTH_FRAC_BITS;
				div_den   = DEN_W'($unsigned(in_q.clip_w));
			end
			OP_BL_DIV: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
			shade_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				CFG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				CFG_SHADE_MODE:    shade_q  <= cfg_wdata[0];
				default:           shade_q  <= shade_q;
			endcase
		end
	end

	// vertex store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i]   <= '0;
				vy_q[i]   <= '0;
				vz_q[i]   <= '0;
				vcol_q[i] <= '0;
			end
			vfront_q <= '0;
		end else if (cmd.op == OP_LD_WRITE) begin
			if (stat.w_pos) begin
				vx_q[in_q.vertex_slot] <= sx_q;
				vy_q[in_q.vertex_slot] <= sy_q;
				vz_q[in_q.vertex_slot] <= sz_q;
			end else begin
				vx_q[in_q.vertex_slot] <= '0;
				vy_q[in_q.vertex_slot] <= '0;
				vz_q[in_q.vertex_slot] <= '0;
			end
			vfront_q[in_q.vertex_slot] <= stat.w_pos;
			vcol_q[in_q.vertex_slot]   <= {in_q.alpha, in_q.blue, in_q.green, in_q.red};
		end
	end

	// fragment depth in Q1.14
	assign dx   = 32'(d_q);
	assign fd_w = 16'((dx >>> FD_SHR) <<< FD_SHL);

	// working registers, stepped by the controller
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= item;
		end
		case (cmd.op)
			OP_LD_MUL_X, OP_LD_MUL_Y, OP_PX_M0, OP_BL_M0: begin
				prod_q <= NUM_W'(prod_w);
			end
			OP_LD_SAVE_X: sx_q <= sat_coord(quo);
			OP_LD_SAVE_Y: sy_q <= sat_coord(quo);
			OP_LD_SAVE_Z: sz_q <= sat_depth(quo);
			OP_PX_M1: begin
				area_q <= E_W'(prod_q);
				prod_q <= NUM_W'(prod_w);
			end
			OP_PX_M2: begin
				area_q <= area_q - E_W'(prod_q);
				prod_q <= NUM_W'(prod_w);
			end
			OP_PX_M3: begin
				e0_q   <= E_W'(prod_q);
				prod_q <= NUM_W'(prod_w);
			end
			OP_PX_M4: begin
				e0_q   <= e0_q + E_W'(prod_q);
				prod_q <= NUM_W'(prod_w);
			end
			OP_PX_M5: begin
				e1_q   <= E_W'(prod_q);
				prod_q <= NUM_W'(prod_w);
			end
			OP_PX_M6: e1_q <= e1_q + E_W'(prod_q);
			OP_PX_E2: e2_q <= area_q - e0_q - e1_q;
			OP_BL_M1: begin
				num_q  <= prod_q;
				prod_q <= NUM_W'(prod_w);
			end
			OP_BL_M2: begin
				num_q  <= num_q + prod_q;
				prod_q <= NUM_W'(prod_w);
			end
			OP_BL_M3: num_q <= num_q + prod_q;
			OP_BL_SAVE: begin
				case (cmd.chan)
					CH_DEPTH: d_q      <= DW'(quo);
					CH_RED:   col_q[0] <= quo[7:0];
					CH_GREEN: col_q[1] <= quo[7:0];
					CH_BLUE:  col_q[2] <= quo[7:0];
					default:  d_q      <= d_q;
				endcase
			end
			OP_EMIT: begin
				res_q.covered         <= cmd.covered;
				res_q.triangle_culled <= culled;
				res_q.frag_depth      <= cmd.covered ? fd_w : 16'sd0;
				if (!cmd.covered) begin
					res_q.out_red   <= 8'h00;
					res_q.out_green <= 8'h00;
					res_q.out_blue  <= 8'h00;
					res_q.out_alpha <= 8'h00;
				end else if (shade_q) begin
					res_q.out_red   <= col_q[0];
					res_q.out_green <= col_q[1];
					res_q.out_blue  <= col_q[2];
					res_q.out_alpha <= 8'hFF;
				end else begin
					res_q.out_red   <= vcol_q[0][7:0];
					res_q.out_green <= vcol_q[0][15:8];
					res_q.out_blue  <= vcol_q[0][23:16];
					res_q.out_alpha <= vcol_q[0][31:24];
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// status toward the controller
	assign culled    = !(&vfront_q) || !area_q[E_W-1];
	assign on_screen = ({1'b0, in_q.pixel_x} < width_q) && ({1'b0, in_q.pixel_y} < height_q);
	assign edges_ok  = (e0_q[E_W-1] || e0_q == '0) && (e1_q[E_W-1] || e1_q == '0)
		&& (e2_q[E_W-1] || e2_q == '0);

	assign stat.div_busy = div_busy;
	assign stat.is_pixel = in_q.func == FUNC_PIXEL;
	assign stat.slot_ok  = in_q.vertex_slot != SLOT_NONE;
	assign stat.w_pos    = !in_q.clip_w[31] && (in_q.clip_w != 32'sd0);
	assign stat.reject   = culled || !on_screen || !edges_ok;
	assign stat.depth_ok = (d_q >= -D_LIM) && (d_q <= D_LIM);
	assign stat.shade    = shade_q;

	assign result = res_q;

endmodule

// ===== src/tfe_ctrl.sv =====
`timescale 1ns / 1ps
// tfe_ctrl: sequencer for vertex loads and pixel evaluation, drives the
// datapath op codes; uses tfe_pkg
module tfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tfe_pkg::dp_status_t stat,
	output tfe_pkg::dp_cmd_t    cmd,
	output logic                busy,
	output logic                result_valid
);
	import tfe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LD_MUL_X,
		ST_LD_DIV_X,
		ST_LD_WAIT_X,
		ST_LD_SAVE_X,
		ST_LD_MUL_Y,
		ST_LD_DIV_Y,
		ST_LD_WAIT_Y,
		ST_LD_SAVE_Y,
		ST_LD_DIV_Z,
		ST_LD_WAIT_Z,
		ST_LD_SAVE_Z,
		ST_LD_WRITE,
		ST_PX_M0,
		ST_PX_M1,
		ST_PX_M2,
		ST_PX_M3,
		ST_PX_M4,
		ST_PX_M5,
		ST_PX_M6,
		ST_PX_E2,
		ST_PX_CHECK,
		ST_BL_M0,
		ST_BL_M1,
		ST_BL_M2,
		ST_BL_M3,
		ST_BL_DIV,
		ST_BL_WAIT,
		ST_BL_SAVE,
		ST_BL_CHECK,
		ST_EMIT
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] chan_q, chan_d;
	logic       cov_q, cov_d;
	logic       valid_q;
	op_t        op;

	// next state
	always_comb begin
		state_d = state_q;
		chan_d  = chan_q;
		cov_d   = cov_q;
		case (state_q)
			ST_IDLE:      if (start) state_d = ST_DECODE;
			ST_DECODE: begin
				cov_d  = 1'b0;
				chan_d = CH_DEPTH;
				if (stat.is_pixel) begin
					state_d = ST_PX_M0;
				end else if (!stat.slot_ok) begin
					state_d = ST_IDLE;
				end else if (stat.w_pos) begin
					state_d = ST_LD_MUL_X;
				end else begin
					state_d = ST_LD_WRITE;
				end
			end
			ST_LD_MUL_X:  state_d = ST_LD_DIV_X;
			ST_LD_DIV_X:  state_d = ST_LD_WAIT_X;
			ST_LD_WAIT_X: if (!stat.div_busy) state_d = ST_LD_SAVE_X;
			ST_LD_SAVE_X: state_d = ST_LD_MUL_Y;
			ST_LD_MUL_Y:  state_d = ST_LD_DIV_Y;
			ST_LD_DIV_Y:  state_d = ST_LD_WAIT_Y;
			ST_LD_WAIT_Y: if (!stat.div_busy) state_d = ST_LD_SAVE_Y;
			ST_LD_SAVE_Y: state_d = ST_LD_DIV_Z;
			ST_LD_DIV_Z:  state_d = ST_LD_WAIT_Z;
			ST_LD_WAIT_Z: if (!stat.div_busy) state_d = ST_LD_SAVE_Z;
			ST_LD_SAVE_Z: state_d = ST_LD_WRITE;
			ST_LD_WRITE:  state_d = ST_IDLE;
			ST_PX_M0:     state_d = ST_PX_M1;
			ST_PX_M1:     state_d = ST_PX_M2;
			ST_PX_M2:     state_d = ST_PX_M3;
			ST_PX_M3:     state_d = ST_PX_M4;
			ST_PX_M4:     state_d = ST_PX_M5;
			ST_PX_M5:     state_d = ST_PX_M6;
			ST_PX_M6:     state_d = ST_PX_E2;
			ST_PX_E2:     state_d = ST_PX_CHECK;
			ST_PX_CHECK:  state_d = stat.reject ? ST_EMIT : ST_BL_M0;
			ST_BL_M0:     state_d = ST_BL_M1;
			ST_BL_M1:     state_d = ST_BL_M2;
			ST_BL_M2:     state_d = ST_BL_M3;
			ST_BL_M3:     state_d = ST_BL_DIV;
			ST_BL_DIV:    state_d = ST_BL_WAIT;
			ST_BL_WAIT:   if (!stat.div_busy) state_d = ST_BL_SAVE;
			ST_BL_SAVE:   state_d = ST_BL_CHECK;
			ST_BL_CHECK: begin
				if (chan_q == CH_DEPTH) begin
					if (!stat.depth_ok) begin
						state_d = ST_EMIT;
					end else if (stat.shade) begin
						cov_d   = 1'b1;
						chan_d  = CH_RED;
						state_d = ST_BL_M0;
					end else begin
						cov_d   = 1'b1;
						state_d = ST_EMIT;
					end
				end else if (chan_q == CH_BLUE) begin
					state_d = ST_EMIT;
				end else begin
					chan_d  = chan_q + 1'b1;
					state_d = ST_BL_M0;
				end
			end
			ST_EMIT:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= CH_DEPTH;
			cov_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chan_q  <= chan_d;
			cov_q   <= cov_d;
			valid_q <= state_q == ST_EMIT;
		end
	end

	// op decode
	always_comb begin
		case (state_q)
			ST_LD_MUL_X:  op = OP_LD_MUL_X;
			ST_LD_DIV_X:  op = OP_LD_DIV_X;
			ST_LD_SAVE_X: op = OP_LD_SAVE_X;
			ST_LD_MUL_Y:  op = OP_LD_MUL_Y;
			ST_LD_DIV_Y:  op = OP_LD_DIV_Y;
			ST_LD_SAVE_Y: op = OP_LD_SAVE_Y;
			ST_LD_DIV_Z:  op = OP_LD_DIV_Z;
			ST_LD_SAVE_Z: op = OP_LD_SAVE_Z;
			ST_LD_WRITE:  op = OP_LD_WRITE;
			ST_PX_M0:     op = OP_PX_M0;
			ST_PX_M1:     op = OP_PX_M1;
			ST_PX_M2:     op = OP_PX_M2;
			ST_PX_M3:     op = OP_PX_M3;
			ST_PX_M4:     op = OP_PX_M4;
			ST_PX_M5:     op = OP_PX_M5;
			ST_PX_M6:     op = OP_PX_M6;
			ST_PX_E2:     op = OP_PX_E2;
			ST_BL_M0:     op = OP_BL_M0;
			ST_BL_M1:     op = OP_BL_M1;
			ST_BL_M2:     op = OP_BL_M2;
			ST_BL_M3:     op = OP_BL_M3;
			ST_BL_DIV:    op = OP_BL_DIV;
			ST_BL_SAVE:   op = OP_BL_SAVE;
			ST_EMIT:      op = OP_EMIT;
			default:      op = OP_NOP;
		endcase
	end

	assign cmd.op       = op;
	assign cmd.capture  = (state_q == ST_IDLE) && start;
	assign cmd.chan     = chan_q;
	assign cmd.covered  = cov_q;
	assign busy         = state_q != ST_IDLE;
	assign result_valid = valid_q;

	// a result strobe always lands back in idle
	assert property (@(posedge clk) disable iff (!arst_n) valid_q |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");

	// an accepted item always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_DECODE)
		else $error("accepted item not decoded");

	// wait states end once the divider is free
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LD_WAIT_X || state_q == ST_LD_WAIT_Y || state_q == ST_LD_WAIT_Z
		|| state_q == ST_BL_WAIT) && !stat.div_busy) |=> state_q != $past(state_q))
		else $error("stuck in divider wait");

	// the divider is never started while it is still running
	assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_LD_DIV_X || op == OP_LD_DIV_Y || op == OP_LD_DIV_Z || op == OP_BL_DIV)
		|-> !stat.div_busy)
		else $error("divider restarted while busy");

endmodule

// ===== src/triangle_fragment_evaluator_core.sv =====
`timescale 1ns / 1ps
// triangle_fragment_evaluator_core: top level, joins controller and datapath;
// uses tfe_pkg, tfe_ctrl, tfe_datapath
//
//  channel   signals                                   transfer when
//  item      start, busy, item                         start && !busy
//  result    result_valid, result                      result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// one item at a time; the shared divider produces one quotient bit per cycle,
// and its divisions set the item time: a vertex load with positive w takes 3
// divisions, one with w not positive none; a culled or missed pixel takes none,
// a flat pixel 1 division, a gouraud pixel 4 divisions (1 if its depth is out of range).
// reset restores the screen size 640x480, flat mode and clears all vertices.
// the result is shown for one cycle and cannot be held off; config is always ready.
module triangle_fragment_evaluator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tfe_pkg::item_t                    item,
	output logic                              result_valid,
	output tfe_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tfe_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	// sequencer
	tfe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// arithmetic and storage
	tfe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.stat      (stat),
		.result    (result)
	);

	assign cfg_ready = 1'b1;

endmodule

// ===== test/tb_triangle_fragment_evaluator_core.sv =====
`timescale 1ns / 1ps
// tb_triangle_fragment_evaluator_core: self-checking bench for the triangle fragment
// evaluator; predicts coverage, depth and color per pixel transfer and checks each result
// depends on tfe_pkg and triangle_fragment_evaluator_core
module tb_triangle_fragment_evaluator_core;
	import tfe_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam longint CMAX = (64'sd1 <<< (COORD_BITS + 8)) - 1;
	localparam longint CMIN = -(64'sd1 <<< (COORD_BITS + 8));
	localparam longint DMAX = (64'sd1 <<< (DEPTH_FRAC_BITS + 1)) - 1;
	localparam longint DMIN = -(64'sd1 <<< (DEPTH_FRAC_BITS + 1));
	localparam longint ONE_Q = 64'sd1 <<< DEPTH_FRAC_BITS;
	localparam longint SPLIT = 2048;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic result_valid;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	longint vtx_sx[3], vtx_sy[3], vtx_nz[3];
	logic [31:0] vtx_rgba[3];
	logic vtx_front[3];
	logic [12:0] scr_w, scr_h;
	logic gouraud;

	result_t frag_queue[$];
	int errors;
	int gap_pct;
	longint cycles = 0;

	triangle_fragment_evaluator_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// floor of weighted sum over area, split so the products stay small
	function automatic longint weighted_floor(longint a0, longint a1, longint a2,
			longint v0, longint v1, longint v2, longint den);
		longint hi0, hi1, hi2, s_hi, s_lo, qh, rh;
		hi0 = fdiv(v0, SPLIT);
		hi1 = fdiv(v1, SPLIT);
		hi2 = fdiv(v2, SPLIT);
		s_hi = a0 * hi0 + a1 * hi1 + a2 * hi2;
		s_lo = a0 * (v0 - hi0 * SPLIT) + a1 * (v1 - hi1 * SPLIT) + a2 * (v2 - hi2 * SPLIT);
		qh = fdiv(s_hi, den);
		rh = s_hi - qh * den;
		return qh * SPLIT + fdiv(rh * SPLIT + s_lo, den);
	endfunction

	// update vertex store or compute the fragment for one accepted item
	task automatic predict_fragment(input item_t it);
		longint x, y, z, w, area, px, py, e0, e1, e2, den, d;
		result_t r;
		int s;
		if (it.func == FUNC_LOAD) begin
			if (it.vertex_slot == SLOT_NONE)
				return;
			s = int'(it.vertex_slot);
			x = it.clip_x;
			y = it.clip_y;
			z = it.clip_z;
			w = it.clip_w;
			vtx_sx[s] = 0;
			vtx_sy[s] = 0;
			vtx_nz[s] = 0;
			if (w > 0) begin
				vtx_sx[s] = clamp(fdiv((x + w) * longint'(scr_w) * 128, w), CMIN, CMAX);
				vtx_sy[s] = clamp(fdiv((w - y) * longint'(scr_h) * 128, w), CMIN, CMAX);
				vtx_nz[s] = clamp(fdiv(z * ONE_Q, w), DMIN, DMAX);
			end
			vtx_front[s] = w > 0;
			vtx_rgba[s] = {it.alpha, it.blue, it.green, it.red};
			return;
		end
		r = '0;
		area = (vtx_sx[1] - vtx_sx[0]) * (vtx_sy[2] - vtx_sy[0])
			- (vtx_sy[1] - vtx_sy[0]) * (vtx_sx[2] - vtx_sx[0]);
		r.triangle_culled = !vtx_front[0] || !vtx_front[1] || !vtx_front[2] || area >= 0;
		if (!r.triangle_culled && it.pixel_x < scr_w && it.pixel_y < scr_h) begin
			px = longint'(it.pixel_x) * 256 + 128;
			py = longint'(it.pixel_y) * 256 + 128;
			e0 = (vtx_sy[1] - vtx_sy[2]) * (px - vtx_sx[2])
				+ (vtx_sx[2] - vtx_sx[1]) * (py - vtx_sy[2]);
			e1 = (vtx_sy[2] - vtx_sy[0]) * (px - vtx_sx[0])
				+ (vtx_sx[0] - vtx_sx[2]) * (py - vtx_sy[0]);
			e2 = area - e0 - e1;
			if (e0 <= 0 && e1 <= 0 && e2 <= 0) begin
				den = -area;
				d = weighted_floor(-e0, -e1, -e2, vtx_nz[0], vtx_nz[1], vtx_nz[2], den);
				if (d >= -ONE_Q && d <= ONE_Q) begin
					r.covered = 1'b1;
					r.frag_depth = 16'((d >>> FD_SHR) <<< FD_SHL);
					if (gouraud) begin
						r.out_red = 8'(weighted_floor(-e0, -e1, -e2, vtx_rgba[0][7:0],
							vtx_rgba[1][7:0], vtx_rgba[2][7:0], den));
						r.out_green = 8'(weighted_floor(-e0, -e1, -e2, vtx_rgba[0][15:8],
							vtx_rgba[1][15:8], vtx_rgba[2][15:8], den));
						r.out_blue = 8'(weighted_floor(-e0, -e1, -e2, vtx_rgba[0][23:16],
							vtx_rgba[1][23:16], vtx_rgba[2][23:16], den));
						r.out_alpha = 8'd255;
					end else begin
						{r.out_alpha, r.out_blue, r.out_green, r.out_red} = vtx_rgba[0];
					end
				end
			end
		end
		frag_queue.push_back(r);
	endtask

	task automatic report(input string name, input longint e, input longint a);
		$display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
		errors++;
	endtask

	// result checker, one transfer per strobe
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid) begin
			if (frag_queue.size() == 0) begin
				$display("%0t unexpected result %p", $time, result);
				errors++;
			end else begin
				e = frag_queue.pop_front();
				if (e.covered !== result.covered)
					report("covered", e.covered, result.covered);
				if (e.triangle_culled !== result.triangle_culled)
					report("triangle_culled", e.triangle_culled, result.triangle_culled);
				if (e.frag_depth !== result.frag_depth)
					report("frag_depth", e.frag_depth, result.frag_depth);
				if (e.out_red !== result.out_red)
					report("out_red", e.out_red, result.out_red);
				if (e.out_green !== result.out_green)
					report("out_green", e.out_green, result.out_green);
				if (e.out_blue !== result.out_blue)
					report("out_blue", e.out_blue, result.out_blue);
				if (e.out_alpha !== result.out_alpha)
					report("out_alpha", e.out_alpha, result.out_alpha);
			end
		end
	end

	// one item transfer, entered and left at a falling edge
	task automatic send_item(input item_t it);
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		predict_fragment(it);
		@(negedge clk);
		start = 1'b0;
		if ($urandom_range(0, 99) < gap_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// drain pending work, then one register transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
		wait (frag_queue.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SCREEN_WIDTH: scr_w = val;
			CFG_SCREEN_HEIGHT: scr_h = val;
			CFG_SHADE_MODE: gouraud = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 13'($urandom);
	endtask

	function automatic item_t vertex_item(logic [1:0] slot, int x, int y, int z, int w);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.func = FUNC_LOAD;
		it.vertex_slot = slot;
		it.clip_x = x;
		it.clip_y = y;
		it.clip_z = z;
		it.clip_w = w;
		return it;
	endfunction

	function automatic item_t pixel_item(int px, int py);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.func = FUNC_PIXEL;
		it.pixel_x = 12'(px);
		it.pixel_y = 12'(py);
		return it;
	endfunction

	// random clip coordinate within [-w, w]
	function automatic int in_frustum(int w);
		return int'($urandom_range(0, 2 * w)) - w;
	endfunction

	// extremes, saturation, ignored slot, culling, zero screen, both shade modes
	task automatic test_directed();
		int q;
		q = 65536;
		send_item(pixel_item(0, 0));
		send_item(vertex_item(SLOT_NONE, q, q, q, q));
		send_item(vertex_item(2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1));
		send_item(vertex_item(2'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 1));
		send_item(vertex_item(2'd2, q, q, q, 0));
		send_item(pixel_item(4095, 4095));
		send_item(vertex_item(2'd2, q, q, q, 32'h80000000));
		send_item(pixel_item(320, 240));
		// a triangle around the screen centre, both windings
		send_item(vertex_item(2'd0, -q / 2, -q / 2, -q / 2, q));
		send_item(vertex_item(2'd1, q / 2, -q / 2, 0, q));
		send_item(vertex_item(2'd2, 0, q / 2, q, q));
		send_item(pixel_item(320, 240));
		send_item(pixel_item(320, 120));
		send_item(pixel_item(639, 479));
		send_item(pixel_item(640, 240));
		write_reg(CFG_SHADE_MODE, 13'd1);
		send_item(pixel_item(320, 300));
		send_item(vertex_item(2'd1, 0, q / 2, q, q));
		send_item(vertex_item(2'd2, q / 2, -q / 2, 0, q));
		send_item(pixel_item(320, 240));
		send_item(pixel_item(330, 330));
		write_reg(CFG_SCREEN_WIDTH, 13'd0);
		write_reg(CFG_SCREEN_HEIGHT, 13'd0);
		send_item(vertex_item(2'd0, -q / 2, -q / 2, -q / 2, q));
		send_item(pixel_item(0, 0));
		write_reg(CFG_SCREEN_WIDTH, 13'd4096);
		write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
		write_reg(CFG_SHADE_MODE, 13'd0);
		send_item(pixel_item(2048, 2048));
	endtask

	function automatic logic [12:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'($urandom_range(65, 700));
			default: return 13'($urandom_range(2, 64));
		endcase
	endfunction

	// random triangles with pixel queries, settings changed now and then
	task automatic test_random_triangles(input int pct, input int tris);
		int w, slot, n;
		gap_pct = pct;
		for (int t = 0; t < tris; t++) begin
			if (t % 10 == 0) begin
				write_reg(CFG_SCREEN_WIDTH, pick_size());
				write_reg(CFG_SCREEN_HEIGHT, pick_size());
				write_reg(CFG_SHADE_MODE, 13'($urandom_range(0, 1)));
			end
			for (slot = 0; slot < 3; slot++) begin
				case ($urandom_range(0, 19))
					0: send_item(vertex_item(2'(slot), $urandom, $urandom, $urandom, $urandom));
					1: send_item(vertex_item(2'(slot), $urandom, $urandom, $urandom,
						-int'($urandom_range(0, 65536))));
					2: send_item(vertex_item(SLOT_NONE, $urandom, $urandom, $urandom, $urandom));
					default: begin
						w = $urandom_range(1 << 12, 4 << 16);
						send_item(vertex_item(2'(slot), in_frustum(w), in_frustum(w),
							in_frustum(w), w));
					end
				endcase
			end
			n = $urandom_range(3, 8);
			for (int p = 0; p < n; p++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(pixel_item($urandom_range(0, 4095), $urandom_range(0, 4095)));
				else
					send_item(pixel_item($urandom_range(0, scr_w - 1),
						$urandom_range(0, scr_h - 1)));
			end
		end
	endtask

	initial begin
		errors = 0;
		gap_pct = 0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scr_w = SCREEN_WIDTH_RST;
		scr_h = SCREEN_HEIGHT_RST;
		gouraud = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vtx_sx[i] = 0;
			vtx_sy[i] = 0;
			vtx_nz[i] = 0;
			vtx_rgba[i] = '0;
			vtx_front[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_triangles(0, 54);
		test_random_triangles(52, 54);
		test_random_triangles(38, 54);
		test_random_triangles(0, 54);

		// drain and let the last item finish
		wait (frag_queue.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && frag_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
